// File: design/swr_pkg.sv
// Package for the stop-and-wait receiver: state and command types, frame
// constants and the frame byte function. No dependencies.
`default_nettype none

package swr_pkg;

   // Input kind codes
   localparam logic [1:0] KIND_START = 2'd0;
   localparam logic [1:0] KIND_BYTE  = 2'd1;
   localparam logic [1:0] KIND_TICK  = 2'd2;

   // Output destinations
   localparam logic DEST_PAYLOAD = 1'b0;
   localparam logic DEST_LINK    = 1'b1;

   localparam logic [15:0] RESET_TIMEOUT = 16'd1000;

   // Header positions inside a packet; payload starts after the header
   localparam int SUM_POS   = 0;
   localparam int SEQ_POS   = 1;
   localparam int TOTAL_POS = 2;
   localparam int HDR_LEN   = 3;

   localparam logic [2:0] FRAME_LAST_IDX = 3'd4;

   localparam logic [7:0] CHAR_G = 8'h47;
   localparam logic [7:0] CHAR_E = 8'h45;
   localparam logic [7:0] CHAR_T = 8'h54;
   localparam logic [7:0] CHAR_A = 8'h41;
   localparam logic [7:0] CHAR_C = 8'h43;
   localparam logic [7:0] CHAR_K = 8'h4B;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_PAY_RD,
      ST_PAY_WR,
      ST_FRAME
   } state_type;

   typedef struct packed {
      logic start;       // new request: reset session, load timer
      logic take_byte;   // buffer one packet byte
      logic tick;        // timer tick
      logic clear_pkt;   // latch packet length, clear buffer
      logic commit;      // packet accepted: update ack state and timer
      logic pay_read;    // read next payload byte from the store
      logic pay_emit;    // load payload byte into output register
      logic frame_emit;  // load next frame byte into output register
   } cmd_type;

   typedef struct packed {
      logic out_free;    // output register can take a result this cycle
      logic timer_fire;  // a tick now would expire the timer
      logic pkt_ok;      // buffered packet passes all checks
      logic pay_more;    // payload bytes remain
      logic frame_last;  // frame byte counter at the final byte
   } status_type;

   // Frame: checksum, three letters, value. ACK when is_ack, else GET.
   function automatic logic [7:0] frame_byte(input logic is_ack, input logic [7:0] val,
                                             input logic [2:0] idx);
      logic [7:0] c0;
      logic [7:0] c1;
      logic [7:0] c2;
      logic [7:0] res;
      c0 = is_ack ? CHAR_A : CHAR_G;
      c1 = is_ack ? CHAR_C : CHAR_E;
      c2 = is_ack ? CHAR_K : CHAR_T;
      case (idx)
         3'd0:    res = c0 ^ c1 ^ c2 ^ val;
         3'd1:    res = c0;
         3'd2:    res = c1;
         3'd3:    res = c2;
         3'd4:    res = val;
         default: res = 8'h00;
      endcase
      return res;
   endfunction

endpackage

`default_nettype wire

// File: design/stop_and_wait_receiver_core.sv
// Top level of the stop-and-wait receiver: controller plus datapath.
// Depends on swr_pkg, swr_ctrl and swr_datapath.
`default_nettype none

// A start transaction sends a 5-byte GET frame. A packet byte is taken
// while idle; the last byte of a packet adds a check and, if the packet
// passes, each payload byte takes a registered read of the packet store and
// a load of the output register, then the payload is closed and the ACK
// frame is sent. A timer tick counts the armed timer down, or reloads it and
// resends a frame when it fires. One transaction is worked at a time;
// req_ready is high while the controller is idle, and the last result may
// still sit in the output register then. The retransmit timeout is set
// through csr_wr_en/csr_wr_data and resets to 1000 ticks.
module stop_and_wait_receiver_core
   import swr_pkg::*;
#(
   parameter int MAX_PACKET = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_kind,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_last_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_destination,
   output logic             rsp_end_of_run,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data
);

   cmd_type    cmd;
   status_type status;

   swr_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_kind      (req_kind),
      .req_last_byte (req_last_byte),
      .status        (status),
      .cmd           (cmd)
   );

   swr_datapath #(
      .MAX_PACKET (MAX_PACKET)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_data_byte   (req_data_byte),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_destination (rsp_destination),
      .rsp_end_of_run  (rsp_end_of_run)
   );

endmodule

`default_nettype wire

// File: design/swr_ctrl.sv
// Controller state machine for the stop-and-wait receiver.
// Depends on swr_pkg; drives commands into swr_datapath.
`default_nettype none

module swr_ctrl
   import swr_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [1:0] req_kind,
   input  wire logic       req_last_byte,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_kind)
                  KIND_START: begin
                     cmd.start = 1'b1;
                     state_in  = ST_FRAME;
                  end
                  KIND_BYTE: begin
                     cmd.take_byte = 1'b1;
                     if (req_last_byte) state_in = ST_CHECK;
                  end
                  KIND_TICK: begin
                     cmd.tick = 1'b1;
                     if (status.timer_fire) state_in = ST_FRAME;
                  end
                  default: ;
               endcase
            end
         end
         ST_CHECK: begin
            cmd.clear_pkt = 1'b1;
            if (status.pkt_ok) begin
               cmd.commit = 1'b1;
               state_in   = ST_PAY_RD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_PAY_RD: begin
            if (status.pay_more) begin
               cmd.pay_read = 1'b1;
               state_in     = ST_PAY_WR;
            end else begin
               state_in = ST_FRAME;
            end
         end
         ST_PAY_WR: begin
            if (status.out_free) begin
               cmd.pay_emit = 1'b1;
               state_in     = ST_PAY_RD;
            end
         end
         ST_FRAME: begin
            if (status.out_free) begin
               cmd.frame_emit = 1'b1;
               if (status.frame_last) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Input only taken while idle; a packet check always follows a last byte
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == ST_IDLE)
      else $error("req_ready outside idle");
   a_last_check: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_kind == KIND_BYTE && req_last_byte) |=>
         state_ff == ST_CHECK)
      else $error("last byte not followed by check");
   a_start_frame: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_kind == KIND_START) |=> state_ff == ST_FRAME)
      else $error("start not followed by frame");

endmodule

`default_nettype wire

// File: design/swr_datapath.sv
// Datapath for the stop-and-wait receiver: packet store, checksum, session
// and timer registers, output register. Depends on swr_pkg.
`default_nettype none

module swr_datapath
   import swr_pkg::*;
#(
   parameter int MAX_PACKET = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     cmd,
   output status_type       status,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_destination,
   output logic             rsp_end_of_run
);

   localparam int CNT_W = $clog2(MAX_PACKET + 2);
   localparam int IDX_W = $clog2(MAX_PACKET);
   localparam logic [CNT_W-1:0] MAX_CNT   = CNT_W'(MAX_PACKET);
   localparam logic [CNT_W-1:0] OVER_CNT  = CNT_W'(MAX_PACKET + 1);
   localparam logic [CNT_W-1:0] HDR_CNT   = CNT_W'(HDR_LEN);
   localparam logic [CNT_W-1:0] SUM_CNT   = CNT_W'(SUM_POS);
   localparam logic [CNT_W-1:0] SEQ_CNT   = CNT_W'(SEQ_POS);
   localparam logic [CNT_W-1:0] TOTAL_CNT = CNT_W'(TOTAL_POS);

   logic [7:0]       store [MAX_PACKET];
   logic [7:0]       rd_data_ff;

   logic [CNT_W-1:0] count_ff;
   logic [7:0]       xor_ff;
   logic [7:0]       hdr_sum_ff;
   logic [7:0]       hdr_seq_ff;
   logic [7:0]       hdr_total_ff;
   logic [7:0]       last_acked_ff;
   logic [7:0]       pending_seq_ff;
   logic [7:0]       requested_ff;
   logic [15:0]      timeout_ff;
   logic [15:0]      timer_left_ff;
   logic             timer_armed_ff;
   logic [CNT_W-1:0] pay_len_ff;
   logic [CNT_W-1:0] pay_idx_ff;
   logic [2:0]       frame_idx_ff;

   logic             out_valid_ff;
   logic [7:0]       out_byte_ff;
   logic             out_dest_ff;
   logic             out_eor_ff;

   logic             room;
   logic             is_ack;

   assign room   = count_ff < MAX_CNT;
   assign is_ack = pending_seq_ff != 8'h00;

   assign status.out_free   = !out_valid_ff || rsp_ready;
   assign status.timer_fire = timer_armed_ff && (timer_left_ff <= 16'd1);
   assign status.pkt_ok     = (count_ff >= HDR_CNT) && (count_ff <= MAX_CNT) &&
                              (hdr_sum_ff == xor_ff) && (hdr_seq_ff > last_acked_ff);
   assign status.pay_more   = pay_idx_ff < pay_len_ff;
   assign status.frame_last = frame_idx_ff == FRAME_LAST_IDX;

   // Packet store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.take_byte && room) begin
         store[count_ff[IDX_W-1:0]] <= req_data_byte;
      end
      if (cmd.pay_read) begin
         rd_data_ff <= store[pay_idx_ff[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= RESET_TIMEOUT;
      end else if (csr_wr_en) begin
         timeout_ff <= csr_wr_data;
      end
   end

   // Packet buffer bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         xor_ff       <= '0;
         hdr_sum_ff   <= '0;
         hdr_seq_ff   <= '0;
         hdr_total_ff <= '0;
         pay_len_ff   <= '0;
         pay_idx_ff   <= '0;
      end else begin
         if (cmd.start) begin
            count_ff <= '0;
            xor_ff   <= '0;
         end else if (cmd.take_byte) begin
            if (room) begin
               count_ff <= count_ff + 1'b1;
               if (count_ff != SUM_CNT) xor_ff <= xor_ff ^ req_data_byte;
               if (count_ff == SUM_CNT) hdr_sum_ff <= req_data_byte;
               if (count_ff == SEQ_CNT) hdr_seq_ff <= req_data_byte;
               if (count_ff == TOTAL_CNT) hdr_total_ff <= req_data_byte;
            end else begin
               count_ff <= OVER_CNT;
            end
         end else if (cmd.clear_pkt) begin
            count_ff   <= '0;
            xor_ff     <= '0;
            pay_len_ff <= count_ff;
            pay_idx_ff <= HDR_CNT;
         end
         if (cmd.pay_emit) pay_idx_ff <= pay_idx_ff + 1'b1;
      end
   end

   // Session and retransmit timer
   always_ff @(posedge clock) begin
      if (reset) begin
         last_acked_ff  <= '0;
         pending_seq_ff <= '0;
         requested_ff   <= '0;
         timer_left_ff  <= '0;
         timer_armed_ff <= 1'b0;
      end else begin
         if (cmd.start) begin
            requested_ff   <= req_data_byte;
            last_acked_ff  <= '0;
            pending_seq_ff <= '0;
            timer_left_ff  <= timeout_ff;
            timer_armed_ff <= 1'b1;
         end else if (cmd.tick && timer_armed_ff) begin
            if (timer_left_ff > 16'd1) timer_left_ff <= timer_left_ff - 16'd1;
            else                       timer_left_ff <= timeout_ff;
         end else if (cmd.commit) begin
            last_acked_ff  <= hdr_seq_ff;
            pending_seq_ff <= hdr_seq_ff;
            if (hdr_seq_ff < hdr_total_ff) begin
               timer_left_ff  <= timeout_ff;
               timer_armed_ff <= 1'b1;
            end else begin
               timer_left_ff  <= '0;
               timer_armed_ff <= 1'b0;
            end
         end
      end
   end

   // Output register and frame byte counter
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         frame_idx_ff <= '0;
      end else begin
         if (cmd.pay_emit || cmd.frame_emit) out_valid_ff <= 1'b1;
         else if (rsp_ready)                 out_valid_ff <= 1'b0;
         if (cmd.frame_emit) begin
            frame_idx_ff <= status.frame_last ? 3'd0 : frame_idx_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pay_emit) begin
         out_byte_ff <= rd_data_ff;
         out_dest_ff <= DEST_PAYLOAD;
         out_eor_ff  <= 1'b0;
      end else if (cmd.frame_emit) begin
         out_byte_ff <= frame_byte(is_ack, is_ack ? pending_seq_ff : requested_ff,
                                   frame_idx_ff);
         out_dest_ff <= DEST_LINK;
         out_eor_ff  <= status.frame_last;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_out_byte    = out_byte_ff;
   assign rsp_destination = out_dest_ff;
   assign rsp_end_of_run  = out_eor_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.pay_emit || cmd.frame_emit) |-> status.out_free)
      else $error("output register overwritten");
   a_eor_on_link: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_end_of_run) |-> rsp_destination == DEST_LINK)
      else $error("run ends on a payload byte");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= OVER_CNT)
      else $error("byte count out of range");
   a_commit_timer: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> timer_armed_ff == $past(hdr_seq_ff < hdr_total_ff))
      else $error("timer arm after accept wrong");

endmodule

`default_nettype wire
